/* hdl/iirdf1_pkg.sv */
// Shared types and constants for the direct-form-I IIR filter.
// No dependencies; every other file except iirdf1_ram imports this package.
package iirdf1_pkg;

  localparam int MAX_ORDER      = 10;
  localparam int SAMPLE_W       = 32;
  localparam int COEF_W         = 32;
  localparam int COEF_FRAC_BITS = 24;

  // Numerator taps b0..bN, denominator taps a1..aN
  localparam int NUM_TAPS    = MAX_ORDER + 1;
  localparam int STORE_DEPTH = NUM_TAPS + MAX_ORDER;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int TAP_W       = 4;
  localparam int XPTR_W      = $clog2(NUM_TAPS);
  localparam int YPTR_W      = $clog2(MAX_ORDER);
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = PROD_W + $clog2(STORE_DEPTH + 1) + 1;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_NUM    = 2'd1;
  localparam logic [1:0] KIND_DEN    = 2'd2;

  localparam logic REG_FILTER_ORDER = 1'b0;
  localparam logic [TAP_W-1:0] ORDER_RESET = 4'd10;

  typedef struct packed {
    logic [1:0]              kind;
    logic [TAP_W-1:0]        tap_index;
    logic signed [31:0]      data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]      filtered_sample;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic subtract;
  } mac_ctl_t;

  typedef struct packed {
    logic                        busy;
    logic signed [SAMPLE_W-1:0]  y;
    logic                        sat;
  } mac_sts_t;

endpackage

/* hdl/iir_filter_direct_form_one.sv */
// Direct-form-I IIR filter, order 0 to 10 (set by filter_order at byte address 0;
// values above 10 act as 10). Input transactions of kind 1 or 2 load one
// numerator or denominator tap; kind 0 carries a Q16.16 sample and yields
// exactly one result transaction, the Q16.16 output rounded half up and
// clamped, with saturated flagging the clamp. Kind 3 is dropped.
// Coefficients and both sample histories live in two 21-entry synchronous RAMs
// (histories as ring buffers), all reading as zero after reset. One shared
// 32x32 multiplier walks the taps one a cycle, so a sample occupies the block
// for its 2*order+1 tap reads, the RAM and multiplier pipeline and the output
// history write. A finished result waits in an output register, so the next
// transaction is taken while it is still pending.
module iir_filter_direct_form_one (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  iirdf1_pkg::in_item_t   in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output iirdf1_pkg::out_item_t  out_item,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import iirdf1_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t            state_r, state_nxt;
  logic [XPTR_W-1:0] xp_r, xp_nxt, xa_r, xa_nxt;
  logic [YPTR_W-1:0] yp_r, yp_nxt, ya_r, ya_nxt;
  logic [TAP_W-1:0]  k_r, k_nxt, ord_r, ord_nxt;
  logic              num_r, num_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;
  mac_ctl_t          ctl_d_r, issue;

  logic [TAP_W-1:0]    filter_order, ord_eff;
  logic                acc_in, acc_samp, finish;
  logic                hist_we, coef_we;
  logic [STORE_AW-1:0] hist_waddr, coef_waddr, hist_raddr, coef_raddr;
  logic [31:0]         hist_wdata, hist_rdata, coef_rdata;
  mac_sts_t            mac_sts;

  iirdf1_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .filter_order
  );

  assign ord_eff  = (filter_order > TAP_W'(MAX_ORDER)) ? TAP_W'(MAX_ORDER) : filter_order;
  assign in_ready = (state_r == ST_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign acc_samp = acc_in && in_item.kind == KIND_SAMPLE;
  // Retire the sample once the accumulator has settled and the output slot is free
  assign finish   = state_r == ST_DRAIN && !ctl_d_r.valid && !mac_sts.busy &&
                    (!out_valid_r || out_ready);

  // Coefficient store: b0..bN at 0..N, a1..aN after them
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = STORE_AW'(in_item.tap_index);
    if (acc_in && in_item.kind == KIND_NUM && in_item.tap_index <= TAP_W'(MAX_ORDER)) begin
      coef_we = 1'b1;
    end
    if (acc_in && in_item.kind == KIND_DEN && in_item.tap_index != '0 &&
        in_item.tap_index <= TAP_W'(MAX_ORDER)) begin
      coef_we    = 1'b1;
      coef_waddr = STORE_AW'(MAX_ORDER) + STORE_AW'(in_item.tap_index);
    end
  end

  // History store: input ring at 0..N, output ring after it. Sample writes and
  // output writes fall in different states, so they never collide.
  always_comb begin
    hist_we    = acc_samp || finish;
    hist_waddr = finish ? STORE_AW'(NUM_TAPS) + STORE_AW'(yp_nxt) : STORE_AW'(xp_nxt);
    hist_wdata = finish ? mac_sts.y : in_item.data_value;
  end

  always_comb begin
    coef_raddr = num_r ? STORE_AW'(k_r) : STORE_AW'(NUM_TAPS) + STORE_AW'(k_r);
    hist_raddr = num_r ? STORE_AW'(xa_r) : STORE_AW'(NUM_TAPS) + STORE_AW'(ya_r);
    issue.valid    = (state_r == ST_RUN);
    issue.first    = num_r && k_r == '0;
    issue.subtract = !num_r;
  end

  iirdf1_ram #(.DEPTH(STORE_DEPTH), .WIDTH(COEF_W)) u_coef_ram (
    .clk, .rst_n, .we(coef_we), .waddr(coef_waddr), .wdata(in_item.data_value),
    .raddr(coef_raddr), .rdata(coef_rdata)
  );

  iirdf1_ram #(.DEPTH(STORE_DEPTH), .WIDTH(SAMPLE_W)) u_hist_ram (
    .clk, .rst_n, .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  iirdf1_mac u_mac (
    .clk, .rst_n, .ctl(ctl_d_r), .coef(coef_rdata), .samp(hist_rdata), .sts(mac_sts)
  );

  // Tap sequencer
  always_comb begin
    state_nxt     = state_r;
    xp_nxt        = xp_r;
    yp_nxt        = yp_r;
    xa_nxt        = xa_r;
    ya_nxt        = ya_r;
    k_nxt         = k_r;
    ord_nxt       = ord_r;
    num_nxt       = num_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    if (acc_samp) begin
      // Advance the input ring and start on b0 against the newest sample
      xp_nxt    = (xp_r == XPTR_W'(NUM_TAPS - 1)) ? '0 : xp_r + 1'b1;
      xa_nxt    = xp_nxt;
      ya_nxt    = yp_r;
      k_nxt     = '0;
      num_nxt   = 1'b1;
      ord_nxt   = ord_eff;
      state_nxt = ST_RUN;
    end
    if (state_r == ST_RUN) begin
      if (num_r) begin
        if (k_r == ord_r) begin
          k_nxt     = '0;
          num_nxt   = 1'b0;
          state_nxt = (ord_r == '0) ? ST_DRAIN : ST_RUN;
        end else begin
          k_nxt  = k_r + 1'b1;
          xa_nxt = (xa_r == '0) ? XPTR_W'(NUM_TAPS - 1) : xa_r - 1'b1;
        end
      end else begin
        if (k_r == ord_r - 1'b1) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt  = k_r + 1'b1;
          ya_nxt = (ya_r == '0) ? YPTR_W'(MAX_ORDER - 1) : ya_r - 1'b1;
        end
      end
    end
    if (finish) begin
      yp_nxt        = (yp_r == YPTR_W'(MAX_ORDER - 1)) ? '0 : yp_r + 1'b1;
      out_valid_nxt = 1'b1;
      out_item_nxt.filtered_sample = mac_sts.y;
      out_item_nxt.saturated       = mac_sts.sat;
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      xp_r        <= '0;
      yp_r        <= '0;
      xa_r        <= '0;
      ya_r        <= '0;
      k_r         <= '0;
      ord_r       <= '0;
      num_r       <= 1'b1;
      out_valid_r <= 1'b0;
      ctl_d_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      xp_r        <= xp_nxt;
      yp_r        <= yp_nxt;
      xa_r        <= xa_nxt;
      ya_r        <= ya_nxt;
      k_r         <= k_nxt;
      ord_r       <= ord_nxt;
      num_r       <= num_nxt;
      out_valid_r <= out_valid_nxt;
      ctl_d_r     <= issue;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Ring pointers stay inside their rings
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    xp_r < XPTR_W'(NUM_TAPS) && yp_r < YPTR_W'(MAX_ORDER))
    else $error("history ring pointer out of range");

  // Nothing is in flight in the MAC pipeline while a new transaction can enter
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !ctl_d_r.valid && !mac_sts.busy)
    else $error("MAC pipeline busy while idle");

  // A retired sample produces a pending result on the next cycle
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r && state_r == ST_IDLE)
    else $error("retired sample lost its result");

  // A sample started with the output ring untouched until it retires
  a_yp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |=> $stable(yp_r))
    else $error("output ring moved mid-sample");

endmodule

/* hdl/iirdf1_ram.sv */
// Generic single-write, single-read synchronous RAM with per-entry valid bits.
// Unwritten entries read as zero. No package dependency.
module iirdf1_ram #(
  parameter int DEPTH = 21,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_r;
  logic             rv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rv_r <= vld_r[raddr];
    end
  end

  assign rdata = rv_r ? rd_r : '0;

endmodule

/* hdl/iirdf1_mac.sv */
// Shared multiply-accumulate with rounding and saturation of the sum.
// Depends on iirdf1_pkg.
module iirdf1_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  iirdf1_pkg::mac_ctl_t                 ctl,
  input  logic signed [iirdf1_pkg::COEF_W-1:0]   coef,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] samp,
  output iirdf1_pkg::mac_sts_t                 sts
);
  import iirdf1_pkg::*;

  localparam int SH_W = ACC_W - COEF_FRAC_BITS;

  logic signed [PROD_W-1:0] prod_r;
  mac_ctl_t                 pctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  rnd;
  logic [SH_W-1:0]          sh;
  logic [SH_W-SAMPLE_W:0]   hi;
  logic                     neg;

  always_ff @(posedge clk) begin
    prod_r <= coef * samp;
    if (pctl_r.valid) begin
      acc_r <= pctl_r.first ? term : acc_r + term;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pctl_r <= '0;
    end else begin
      pctl_r <= ctl;
    end
  end

  always_comb begin
    prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    term     = pctl_r.subtract ? -prod_ext : prod_ext;
  end

  // Round half up, then clamp to the sample range
  always_comb begin
    rnd = acc_r + {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    sh  = rnd[ACC_W-1:COEF_FRAC_BITS];
    hi  = sh[SH_W-1:SAMPLE_W-1];
    neg = rnd[ACC_W-1];
    sts.busy = pctl_r.valid;
    sts.sat  = neg ? ~&hi : |hi;
    if (sts.sat) begin
      sts.y = neg ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sts.y = sh[SAMPLE_W-1:0];
    end
  end

endmodule

/* hdl/iirdf1_regs.sv */
// APB-style configuration register block: holds the filter order.
// Depends on iirdf1_pkg.
module iirdf1_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [iirdf1_pkg::TAP_W-1:0]  filter_order
);
  import iirdf1_pkg::*;

  logic [TAP_W-1:0] order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FILTER_ORDER) begin
      order_r <= pwdata[TAP_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FILTER_ORDER: prdata = {{(32-TAP_W){1'b0}}, order_r};
      default:          prdata = '0;
    endcase
  end

  assign pready       = 1'b1;
  assign filter_order = order_r;

endmodule

/* test/iirdf1_response_check.sv */
`timescale 1ns / 100ps
// Result checker for the direct-form-I IIR filter: follows filter_order writes,
// predicts each result from its own taps and histories, and compares in order.
// Depends on iirdf1_pkg only.
module iirdf1_response_check (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  iirdf1_pkg::in_item_t  in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  iirdf1_pkg::out_item_t out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  end_check,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_checked,
  output int                    clipped_results
);
  import iirdf1_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  localparam logic [2:0] ORDER_ADDR = {REG_FILTER_ORDER, 2'b00};

  sample_t          x_hist [NUM_TAPS];
  sample_t          y_hist [MAX_ORDER];
  coef_t            b_taps [NUM_TAPS];
  coef_t            a_taps [MAX_ORDER];
  logic [TAP_W-1:0] order_q = ORDER_RESET;
  out_item_t        expected_outputs [$];
  int               err_count = 0;
  int               checked_count = 0;
  int               clip_count = 0;
  bit               leftover_done = 1'b0;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
    clipped_results = 0;
  end

  // Shift the sample in, run the exact sum, round half up and clamp
  function automatic out_item_t filter_sample(input sample_t x);
    logic signed [127:0] acc;
    logic signed [63:0]  prod;
    out_item_t           res;
    int                  taps;
    taps = (order_q > MAX_ORDER) ? MAX_ORDER : int'(order_q);
    for (int i = NUM_TAPS - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
    x_hist[0] = x;
    acc = '0;
    for (int i = 0; i <= taps; i++) begin
      prod = b_taps[i] * x_hist[i];
      acc += prod;
    end
    for (int i = 0; i < taps; i++) begin
      prod = a_taps[i] * y_hist[i];
      acc -= prod;
    end
    acc += 128'sd1 <<< (COEF_FRAC_BITS - 1);
    acc = acc >>> COEF_FRAC_BITS;
    res.saturated = 1'b1;
    if (acc > 128'sd2147483647) begin
      res.filtered_sample = 32'sh7FFF_FFFF;
    end else if (acc < -128'sd2147483648) begin
      res.filtered_sample = 32'sh8000_0000;
    end else begin
      res.saturated       = 1'b0;
      res.filtered_sample = acc[31:0];
    end
    for (int i = MAX_ORDER - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    y_hist[0] = res.filtered_sample;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (x_hist[i]) x_hist[i] = '0;
      foreach (b_taps[i]) b_taps[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
      foreach (a_taps[i]) a_taps[i] = '0;
      order_q = ORDER_RESET;
      expected_outputs.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ORDER_ADDR)
        order_q = pwdata[TAP_W-1:0];

      // Retire before predicting, so a result never meets its own prediction
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h sat %b",
                   $time, out_item.filtered_sample, out_item.saturated);
          err_count++;
        end else begin
          want = expected_outputs.pop_front();
          checked_count++;
          if (want.saturated) clip_count++;
          if (out_item.filtered_sample !== want.filtered_sample) begin
            $display("%0t: filtered_sample: expected %h, actual %h",
                     $time, want.filtered_sample, out_item.filtered_sample);
            err_count++;
          end
          if (out_item.saturated !== want.saturated) begin
            $display("%0t: saturated: expected %b, actual %b",
                     $time, want.saturated, out_item.saturated);
            err_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        case (in_item.kind)
          KIND_SAMPLE: expected_outputs.push_back(filter_sample(in_item.data_value));
          KIND_NUM: begin
            if (in_item.tap_index <= MAX_ORDER) b_taps[in_item.tap_index] = in_item.data_value;
          end
          KIND_DEN: begin
            if (in_item.tap_index >= 1 && in_item.tap_index <= MAX_ORDER)
              a_taps[in_item.tap_index - 1] = in_item.data_value;
          end
          default: ;
        endcase
      end

      if (end_check && !leftover_done) begin
        leftover_done = 1'b1;
        if (expected_outputs.size() != 0) begin
          $display("%0t: results missing: expected %0d more, actual 0",
                   $time, expected_outputs.size());
          err_count += expected_outputs.size();
        end
      end
    end
    mismatches      <= err_count;
    outstanding     <= expected_outputs.size();
    results_checked <= checked_count;
    clipped_results <= clip_count;
  end

endmodule

/* test/iir_filter_direct_form_one_tb.sv */
`timescale 1ns / 100ps
// Top-level bench for iir_filter_direct_form_one: drives coefficient loads, samples
// and filter_order writes, and gives the verdict. Needs iirdf1_pkg, the block and
// iirdf1_response_check.
module iir_filter_direct_form_one_tb;
  import iirdf1_pkg::*;

  localparam logic [1:0] KIND_UNUSED       = 2'd3;
  localparam logic [2:0] ADDR_FILTER_ORDER = {REG_FILTER_ORDER, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
  // A sample holds the block through its tap reads and the MAC pipeline; give it room to finish
  localparam int SETTLE_CYCLES   = 2 * MAX_ORDER + 20;
  localparam int LONG_HOLD       = 400;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int CYCLE_LIMIT     = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        end_check = 1'b0;

  int mismatches, outstanding, results_checked, clipped_results;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_request = 1'b0;
  int items_sent = 0;
  int cycle_count = 0;
  logic [TAP_W-1:0] phase_orders [PHASES];

  iir_filter_direct_form_one dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  iirdf1_response_check checker_inst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .end_check       (end_check),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .clipped_results (clipped_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[iir_filter_direct_form_one] ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, or a long hold-off counted here once
  // requested, so the output register fills and in_ready drops
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t make_item(logic [1:0] kind, logic [TAP_W-1:0] tap,
                                         logic [31:0] data);
    in_item_t it;
    it.kind       = kind;
    it.tap_index  = tap;
    it.data_value = data;
    return it;
  endfunction

  // Mostly small samples and gentle taps so the filter stays stable; a share of
  // full-range words drives saturation and toggles every bit
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    it.kind = (pick < 70) ? KIND_SAMPLE :
              (pick < 82) ? KIND_NUM    :
              (pick < 94) ? KIND_DEN    : KIND_UNUSED;
    it.tap_index = ($urandom_range(99) < 20) ? TAP_W'($urandom_range(15)) :
                                               TAP_W'($urandom_range(MAX_ORDER));
    if ($urandom_range(99) < 14)
      it.data_value = $urandom;
    else
      it.data_value = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    return it;
  endfunction

  // Offer one transaction; hold valid and payload until it is taken
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Register write: setup phase, then access phase, then the bus returns to idle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and wait for every predicted result; optionally let a trailing
  // coefficient load or sample finish inside the block as well
  task automatic settle_outputs(input bit let_block_finish);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    if (let_block_finish) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_item_t directed [$];

    // Order extremes first, then a random middle value, order 1 and a random setting
    phase_orders = '{4'd10, 4'd0, 4'd15, 4'd5, 4'd1, 4'd10};
    phase_orders[3] = TAP_W'($urandom_range(1, MAX_ORDER - 1));
    phase_orders[5] = TAP_W'($urandom_range(15));

    // Directed part, run at the reset order with no idling
    directed.push_back(make_item(KIND_SAMPLE, 4'd0,  32'h7FFF_FFFF)); // all taps zero
    directed.push_back(make_item(KIND_NUM,    4'd0,  32'h7FFF_FFFF)); // largest b0
    directed.push_back(make_item(KIND_SAMPLE, 4'd5,  32'h7FFF_FFFF)); // clips high
    directed.push_back(make_item(KIND_SAMPLE, 4'd15, 32'h8000_0000)); // clips low
    directed.push_back(make_item(KIND_NUM,    4'd0,  32'h8000_0000)); // most negative b0
    directed.push_back(make_item(KIND_SAMPLE, 4'd0,  32'h8000_0000)); // negative times negative
    directed.push_back(make_item(KIND_NUM,    4'd0,  32'h0080_0000)); // b0 = one half
    directed.push_back(make_item(KIND_SAMPLE, 4'd0,  32'h0000_0001)); // half an LSB rounds up
    directed.push_back(make_item(KIND_SAMPLE, 4'd0,  32'hFFFF_FFFF)); // minus half rounds to zero
    directed.push_back(make_item(KIND_NUM,    4'd10, 32'h0100_0000)); // top numerator tap
    directed.push_back(make_item(KIND_DEN,    4'd1,  32'h0080_0000)); // a1
    directed.push_back(make_item(KIND_DEN,    4'd10, 32'hFF00_0000)); // top denominator tap
    directed.push_back(make_item(KIND_DEN,    4'd0,  32'h7FFF_FFFF)); // a0 never stored
    directed.push_back(make_item(KIND_NUM,    4'd11, 32'h7FFF_FFFF)); // numerator index too high
    directed.push_back(make_item(KIND_DEN,    4'd15, 32'h8000_0000)); // denominator index too high
    directed.push_back(make_item(KIND_UNUSED, 4'd3,  32'h7FFF_FFFF)); // unused kind, dropped
    directed.push_back(make_item(KIND_SAMPLE, 4'd0,  32'h0001_0000));
    directed.push_back(make_item(KIND_SAMPLE, 4'd0,  32'h7FFF_FFFF));
    directed.push_back(make_item(KIND_SAMPLE, 4'd0,  32'h0000_0000));
    directed.push_back(make_item(KIND_SAMPLE, 4'd0,  32'h8000_0000));
    directed.push_back(make_item(KIND_SAMPLE, 4'd0,  32'h5555_AAAA));
    directed.push_back(make_item(KIND_SAMPLE, 4'd0,  32'hAAAA_5555));

    // Hold reset, then release it for good
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i]);
    settle_outputs(1'b1);

    // Random part: receiver-stall-heavy phases, then sender-idle-heavy, then none
    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct   = (phase < 2) ? 20 : (phase < 4) ? 52 : 0;
      recv_stall_pct <= (phase < 2) ? 52 : (phase < 4) ? 20 : 0;
      if (phase == 3) write_reg(ADDR_UNMAPPED, 32'hFFFF_FFF1);   // must change nothing
      write_reg(ADDR_FILTER_ORDER, {28'h0, phase_orders[phase]});
      if (phase == 2) begin
        // Starve the result side while samples keep coming
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 4 && n == ITEMS_PER_PHASE / 2) settle_outputs(1'b0);
        send_item(random_item());
      end
      settle_outputs(1'b1);
    end

    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Run covered %0d input transactions at %0d order settings;", items_sent,
             PHASES + 1);
    $display("%0d results compared, %0d of them clipped.", results_checked, clipped_results);
    if (mismatches == 0) begin
      $display("[iir_filter_direct_form_one] OK");
    end else begin
      $display("[iir_filter_direct_form_one] ERROR");
    end
    $finish;
  end

endmodule
